>>> rtl/box_circle_collision_manifold_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the collision manifold block
// Same-cycle implication and next-cycle checks, compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef BOX_CIRCLE_COLLISION_MANIFOLD_ASSERT_SVH
`define BOX_CIRCLE_COLLISION_MANIFOLD_ASSERT_SVH

`ifndef ASSERT_OFF
`define BCCM_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("bccm assertion failed");
`define BCCM_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("bccm assertion failed");
`else
`define BCCM_ASSERT_SAME(lbl, ck, rs, ante, cons)
`define BCCM_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif

`endif

>>> rtl/bccm_pkg.sv
// ----------------------------------------------------------------------------
// bccm_pkg
// Shared types and constants of the collision manifold block.
// ----------------------------------------------------------------------------
`default_nettype none

package bccm_pkg;

  localparam int POS_W  = 24;  // Q16.8 positions
  localparam int SIZE_W = 22;  // Q14.8 sizes and radii
  localparam int PEN_W  = 23;  // Q15.8 penetration
  localparam int NRM_W  = 16;  // Q1.14 normal components
  localparam int TOL_W  = 8;
  localparam int CW     = 27;  // internal coordinate / difference width
  localparam int MAG_W  = 23;  // |dx|, |dy| once known below the radius
  localparam int SQ_W   = 2 * MAG_W;
  localparam int D2_W   = SQ_W + 1;
  localparam int ROOT_W = 32;  // floor(sqrt(dist2 * 2^16))
  localparam int QUO_W  = 16;
  localparam int DIV_SH = 22;  // 14 normal + 16 root - 8 magnitude fraction bits
  localparam int NUM_W  = ROOT_W + QUO_W;

  localparam logic [TOL_W-1:0] TOL_RESET = 8'd1;
  localparam logic signed [NRM_W-1:0] NRM_ONE  = 16'sd16384;
  localparam logic signed [NRM_W-1:0] NRM_NEG  = -16'sd16384;
  localparam logic signed [NRM_W-1:0] NRM_ZERO = 16'sd0;
  localparam logic [QUO_W-1:0] Q_ONE = 16'd16384;

  typedef enum logic [1:0] {
    KIND_BB = 2'd0,
    KIND_BC = 2'd1,
    KIND_CB = 2'd2,
    KIND_CC = 2'd3
  } kind_t;

  typedef logic signed [CW-1:0]    crd_t;
  typedef logic signed [NRM_W-1:0] nrm_t;

endpackage

`default_nettype wire

>>> rtl/bccm_if.sv
// ----------------------------------------------------------------------------
// bccm channel interfaces
// Request, response and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bccm_in_if;
  import bccm_pkg::*;
  logic                     valid;
  logic                     ready;
  kind_t                    kind;
  logic signed [POS_W-1:0]  a_x;
  logic signed [POS_W-1:0]  a_y;
  logic        [SIZE_W-1:0] a_w;
  logic        [SIZE_W-1:0] a_h;
  logic signed [POS_W-1:0]  b_x;
  logic signed [POS_W-1:0]  b_y;
  logic        [SIZE_W-1:0] b_w;
  logic        [SIZE_W-1:0] b_h;
  logic                     b_trigger;
  modport source (output valid, kind, a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h,
                  b_trigger, input ready);
  modport sink (input valid, kind, a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h,
                b_trigger, output ready);
endinterface

interface bccm_out_if;
  import bccm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic        [PEN_W-1:0] penetration;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  modport source (output valid, hit, penetration, normal_x, normal_y, input ready);
  modport sink (input valid, hit, penetration, normal_x, normal_y, output ready);
endinterface

interface bccm_cfg_if;
  import bccm_pkg::*;
  logic             valid;
  logic             ready;
  logic [TOL_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/bccm_sqrt.sv
// ----------------------------------------------------------------------------
// bccm_sqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bccm_sqrt #(
  parameter int RW = bccm_pkg::ROOT_W
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] arg,
  output logic [RW-1:0]   root
);

  localparam int AW = 2 * RW;

  logic [AW-1:0] rem_r [RW];
  logic [RW-1:0] rt_r  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int I = RW - 1 - k;
    logic [AW-1:0] rem_in;
    logic [AW-1:0] trial;
    logic [RW-1:0] rt_in;
    logic [RW-1:0] rt_set;

    if (k == 0) begin : g_first
      assign rem_in = arg;
      assign rt_in  = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign rt_in  = rt_r[k-1];
    end

    // (root + 2^i)^2 - root^2 = root * 2^(i+1) + 2^(2i)
    always_comb begin
      trial  = (AW'(rt_in) << (I + 1)) | (AW'(1) << (2 * I));
      rt_set = rt_in | (RW'(1) << I);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_r[k] <= rem_in - trial;
          rt_r[k]  <= rt_set;
        end else begin
          rem_r[k] <= rem_in;
          rt_r[k]  <= rt_in;
        end
      end
    end
  end

  assign root = rt_r[RW-1];

endmodule

`default_nettype wire

>>> rtl/bccm_div.sv
// ----------------------------------------------------------------------------
// bccm_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bccm_div #(
  parameter int NW = bccm_pkg::NUM_W,
  parameter int DW = bccm_pkg::ROOT_W,
  parameter int QW = bccm_pkg::QUO_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] dv_r  [QW];
  logic [QW-1:0] q_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int I = QW - 1 - k;
    logic [NW-1:0] rem_in;
    logic [NW-1:0] trial;
    logic [DW-1:0] dv_in;
    logic [QW-1:0] q_in;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign dv_in  = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dv_in  = dv_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign trial = NW'(dv_in) << I;

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k] <= dv_in;
        if (rem_in >= trial) begin
          rem_r[k] <= rem_in - trial;
          q_r[k]   <= q_in | (QW'(1) << I);
        end else begin
          rem_r[k] <= rem_in;
          q_r[k]   <= q_in;
        end
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule

`default_nettype wire

>>> rtl/box_circle_collision_manifold.sv
// ----------------------------------------------------------------------------
// box_circle_collision_manifold
// Narrow-phase contact for one box/circle collider pair per beat.
// ----------------------------------------------------------------------------
//
//  channel | dir | fields                                   | beat moves
//  --------+-----+------------------------------------------+-----------------
//  cfg     | in  | data (overlap_tolerance)                 | one register write
//  req     | in  | kind, a_x..a_h, b_x..b_h, b_trigger       | one collider pair
//  rsp     | out | hit, penetration, normal_x, normal_y      | one manifold
//
//  One pair enters per cycle while no stall on rsp holds the pipe.
//  Depth is set by the bit-serial square root (32 stages) and the normal
//  divider (16 stages), both fully pipelined.
//  rst is synchronous: all valid bits clear and the tolerance returns to 1.
//  A stall on rsp holds every stage in place; req.ready falls while the
//  output beat waits, so no beat is dropped or repeated.
//
`default_nettype none
`include "box_circle_collision_manifold_assert.svh"

module box_circle_collision_manifold (
  input  logic       clk,
  input  logic       rst,
  bccm_cfg_if.sink   cfg,
  bccm_in_if.sink    req,
  bccm_out_if.source rsp
);

  import bccm_pkg::*;

  localparam int SQ_LAT = ROOT_W;
  localparam int DV_LAT = QUO_W;

  // Stage 1: box corners, pair in canonical order (box first for mixed kinds)
  typedef struct packed {
    kind_t             kind;
    logic              trig;
    crd_t              p0x, p0y, p1x, p1y;
    crd_t              q0x, q0y, q1x, q1y;
    logic [PEN_W-1:0]  rad;
  } s1_t;

  // Stage 2: overlaps and differences
  typedef struct packed {
    kind_t             kind;
    logic              trig;
    crd_t              ovx, ovy;
    crd_t              dx, dy;
    crd_t              l, rt, t, bt;
    logic              ax_lt, ay_lt;
    logic [PEN_W-1:0]  rad;
  } s2_t;

  // Stage 3 onward up to the root
  typedef struct packed {
    kind_t             kind;
    logic              trig;
    logic              hit;
    logic              dz;
    logic [PEN_W-1:0]  pen_fix;
    nrm_t              nfx, nfy;
    logic [MAG_W-1:0]  mx, my;
    logic              sx, sy;
    logic [PEN_W-1:0]  rad;
  } sb_t;

  // After the root, through the divider
  typedef struct packed {
    kind_t             kind;
    logic              trig;
    logic              hit;
    logic              dzero;
    logic [PEN_W-1:0]  pen;
    nrm_t              nfx, nfy;
    logic              sx, sy;
  } pb_t;

  logic [TOL_W-1:0] tol;
  logic             en;

  s1_t s1, s1_next;
  s2_t s2, s2_next;
  sb_t s3, s3_next;
  sb_t s4, s5, s5_next;
  logic v1, v2, v3, v4, v5, v6, ov;

  logic [SQ_W-1:0]   sqx, sqy, r2;
  logic [D2_W-1:0]   dist2;
  logic [2*ROOT_W-1:0] sq_arg;
  logic [ROOT_W-1:0] root;

  sb_t               sq_line [SQ_LAT];
  logic [SQ_LAT-1:0] sq_v;

  pb_t               s6, s6_next;
  logic [NUM_W-1:0]  numx, numy;
  logic [ROOT_W-1:0] den;
  logic [QUO_W-1:0]  qx, qy;

  pb_t               dv_line [DV_LAT];
  logic [DV_LAT-1:0] dv_v;

  logic              out_hit;
  logic [PEN_W-1:0]  out_pen;
  nrm_t              out_nx, out_ny;

  // Whole pipe advances together; it only holds when the output beat waits.
  assign en        = !ov || rsp.ready;
  assign req.ready = en;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg.valid) begin
      tol <= cfg.data;
    end
  end

  // ---- stage 1: order operands, box max corners, circle radius or radius sum ----
  always_comb begin
    logic              swap;
    logic signed [POS_W-1:0] px, py, qx_i, qy_i;
    logic [SIZE_W-1:0] pw, ph, qw, qh;
    swap = (req.kind == KIND_CB);
    px   = swap ? req.b_x : req.a_x;
    py   = swap ? req.b_y : req.a_y;
    pw   = swap ? req.b_w : req.a_w;
    ph   = swap ? req.b_h : req.a_h;
    qx_i = swap ? req.a_x : req.b_x;
    qy_i = swap ? req.a_y : req.b_y;
    qw   = swap ? req.a_w : req.b_w;
    qh   = swap ? req.a_h : req.b_h;
    s1_next.kind = req.kind;
    s1_next.trig = req.b_trigger;
    s1_next.p0x  = crd_t'(px);
    s1_next.p0y  = crd_t'(py);
    s1_next.p1x  = crd_t'(px) + crd_t'($signed({1'b0, pw}));
    s1_next.p1y  = crd_t'(py) + crd_t'($signed({1'b0, ph}));
    s1_next.q0x  = crd_t'(qx_i);
    s1_next.q0y  = crd_t'(qy_i);
    s1_next.q1x  = crd_t'(qx_i) + crd_t'($signed({1'b0, qw}));
    s1_next.q1y  = crd_t'(qy_i) + crd_t'($signed({1'b0, qh}));
    if (req.kind == KIND_CC) begin
      s1_next.rad = PEN_W'(req.a_w) + PEN_W'(req.b_w);
    end else begin
      s1_next.rad = PEN_W'(qw);  // circle radius sits in the second slot
    end
  end

  // ---- stage 2: axis overlaps, center-to-box or center-to-center offsets ----
  always_comb begin
    crd_t hix, hiy, lox, loy, bdx, bdy;
    hix = (s1.p1x < s1.q1x) ? s1.p1x : s1.q1x;
    hiy = (s1.p1y < s1.q1y) ? s1.p1y : s1.q1y;
    lox = (s1.p0x > s1.q0x) ? s1.p0x : s1.q0x;
    loy = (s1.p0y > s1.q0y) ? s1.p0y : s1.q0y;
    // offset of circle center from its clamped point on the box
    if (s1.q0x < s1.p0x) begin
      bdx = s1.q0x - s1.p0x;
    end else if (s1.q0x > s1.p1x) begin
      bdx = s1.q0x - s1.p1x;
    end else begin
      bdx = '0;
    end
    if (s1.q0y < s1.p0y) begin
      bdy = s1.q0y - s1.p0y;
    end else if (s1.q0y > s1.p1y) begin
      bdy = s1.q0y - s1.p1y;
    end else begin
      bdy = '0;
    end
    s2_next.kind  = s1.kind;
    s2_next.trig  = s1.trig;
    s2_next.ovx   = hix - lox;
    s2_next.ovy   = hiy - loy;
    s2_next.dx    = (s1.kind == KIND_CC) ? s1.p0x - s1.q0x : bdx;
    s2_next.dy    = (s1.kind == KIND_CC) ? s1.p0y - s1.q0y : bdy;
    s2_next.l     = s1.q0x - s1.p0x;
    s2_next.rt    = s1.p1x - s1.q0x;
    s2_next.t     = s1.q0y - s1.p0y;
    s2_next.bt    = s1.p1y - s1.q0y;
    s2_next.ax_lt = s1.p0x < s1.q0x;
    s2_next.ay_lt = s1.p0y < s1.q0y;
    s2_next.rad   = s1.rad;
  end

  // ---- stage 3: box-box verdict, radius pre-check, magnitudes, axis-snapped normals ----
  always_comb begin
    crd_t             tolc, mx, my, radc, mlr, mtb;
    logic             bb_hit, near, dz;
    logic [PEN_W-1:0] bb_pen;
    nrm_t             bbx, bby, snx, sny, inx, iny;
    tolc   = crd_t'($signed({1'b0, tol}));
    bb_hit = !((s2.ovx < -tolc) || (s2.ovy < -tolc));
    // least overlap axis, y on a tie
    if (s2.ovx < s2.ovy) begin
      bb_pen = (s2.ovx < 0) ? '0 : s2.ovx[PEN_W-1:0];
      bbx    = s2.ax_lt ? NRM_NEG : NRM_ONE;
      bby    = NRM_ZERO;
    end else begin
      bb_pen = (s2.ovy < 0) ? '0 : s2.ovy[PEN_W-1:0];
      bbx    = NRM_ZERO;
      bby    = s2.ay_lt ? NRM_NEG : NRM_ONE;
    end
    mx   = (s2.dx < 0) ? -s2.dx : s2.dx;
    my   = (s2.dy < 0) ? -s2.dy : s2.dy;
    radc = crd_t'($signed({1'b0, s2.rad}));
    // an axis gap past the radius rules out a hit and keeps squares narrow
    if (s2.kind == KIND_CC) begin
      near = (mx < radc) && (my < radc);
    end else begin
      near = (mx <= radc) && (my <= radc);
    end
    dz = (s2.dx == '0) && (s2.dy == '0);
    if (mx > my) begin
      snx = (s2.dx > 0) ? NRM_ONE : NRM_NEG;
      sny = NRM_ZERO;
    end else begin
      snx = NRM_ZERO;
      sny = (s2.dy > 0) ? NRM_ONE : NRM_NEG;
    end
    // center inside the box: push out through the nearest face
    mlr = (s2.l < s2.rt) ? s2.l : s2.rt;
    mtb = (s2.t < s2.bt) ? s2.t : s2.bt;
    if (mlr < mtb) begin
      inx = (s2.l < s2.rt) ? NRM_NEG : NRM_ONE;
      iny = NRM_ZERO;
    end else begin
      inx = NRM_ZERO;
      iny = (s2.t < s2.bt) ? NRM_NEG : NRM_ONE;
    end
    s3_next.kind    = s2.kind;
    s3_next.trig    = s2.trig;
    s3_next.hit     = (s2.kind == KIND_BB) ? bb_hit : near;
    s3_next.dz      = dz;
    s3_next.pen_fix = (s2.kind == KIND_BB) ? bb_pen : s2.rad;
    s3_next.nfx     = (s2.kind == KIND_BB) ? bbx : (dz ? inx : snx);
    s3_next.nfy     = (s2.kind == KIND_BB) ? bby : (dz ? iny : sny);
    s3_next.mx      = mx[MAG_W-1:0];
    s3_next.my      = my[MAG_W-1:0];
    s3_next.sx      = s2.dx < 0;
    s3_next.sy      = s2.dy < 0;
    s3_next.rad     = s2.rad;
  end

  // ---- stage 5 verdict: squared distance against squared radius ----
  always_comb begin
    logic [D2_W-1:0] d2;
    s5_next = s4;
    d2      = D2_W'(sqx) + D2_W'(sqy);
    case (s4.kind) inside
      KIND_BB:          s5_next.hit = s4.hit;
      KIND_BC, KIND_CB: s5_next.hit = s4.hit && (d2 <= D2_W'(r2));
      KIND_CC:          s5_next.hit = s4.hit && (d2 < D2_W'(r2));
      default:          s5_next.hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1  <= s1_next;
      s2  <= s2_next;
      s3  <= s3_next;
      // stage 4: squares
      s4  <= s3;
      sqx <= SQ_W'(s3.mx) * SQ_W'(s3.mx);
      sqy <= SQ_W'(s3.my) * SQ_W'(s3.my);
      r2  <= SQ_W'(s3.rad) * SQ_W'(s3.rad);
      // stage 5: squared distance and hit verdict
      s5    <= s5_next;
      dist2 <= D2_W'(sqx) + D2_W'(sqy);
    end
  end

  // ---- root: floor(sqrt(dist2 * 2^16)) ----
  assign sq_arg = {1'b0, dist2, 16'b0};

  bccm_sqrt #(.RW(ROOT_W)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .arg  (sq_arg),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sq_line[0] <= s5;
      for (int k = 1; k < SQ_LAT; k++) begin
        sq_line[k] <= sq_line[k-1];
      end
    end
  end

  // ---- stage 6: penetration from the root or the fixed value, divider operands ----
  always_comb begin
    sb_t              sb;
    logic [PEN_W-1:0] pen_c;
    sb    = sq_line[SQ_LAT-1];
    pen_c = PEN_W'({1'b0, sb.rad} - root[ROOT_W-1:8]);
    s6_next.kind  = sb.kind;
    s6_next.trig  = sb.trig;
    s6_next.hit   = sb.hit;
    s6_next.dzero = (root == '0);
    if (sb.kind == KIND_BB || (sb.kind != KIND_CC && sb.dz)) begin
      s6_next.pen = sb.pen_fix;
    end else begin
      s6_next.pen = pen_c;
    end
    s6_next.nfx = sb.nfx;
    s6_next.nfy = sb.nfy;
    s6_next.sx  = sb.sx;
    s6_next.sy  = sb.sy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6   <= s6_next;
      den  <= root;
      // |diff| * 2^22 plus half the divisor: rounds the quotient to nearest
      numx <= NUM_W'({sq_line[SQ_LAT-1].mx, DIV_SH'(0)}) + NUM_W'(root[ROOT_W-1:1]);
      numy <= NUM_W'({sq_line[SQ_LAT-1].my, DIV_SH'(0)}) + NUM_W'(root[ROOT_W-1:1]);
    end
  end

  bccm_div #(.NW(NUM_W), .DW(ROOT_W), .QW(QUO_W)) u_div_x (
    .clk (clk),
    .en  (en),
    .num (numx),
    .den (den),
    .quo (qx)
  );

  bccm_div #(.NW(NUM_W), .DW(ROOT_W), .QW(QUO_W)) u_div_y (
    .clk (clk),
    .en  (en),
    .num (numy),
    .den (den),
    .quo (qy)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dv_line[0] <= s6;
      for (int k = 1; k < DV_LAT; k++) begin
        dv_line[k] <= dv_line[k-1];
      end
    end
  end

  // ---- output stage: saturate, sign, pick by kind, blank misses ----
  always_comb begin
    pb_t  pb;
    nrm_t cx, cy, nx, ny;
    pb = dv_line[DV_LAT-1];
    cx = (qx > Q_ONE) ? NRM_ONE : nrm_t'(qx);
    cy = (qy > Q_ONE) ? NRM_ONE : nrm_t'(qy);
    case (pb.kind) inside
      KIND_BB, KIND_BC: begin
        nx = pb.nfx;
        ny = pb.nfy;
      end
      KIND_CB: begin
        nx = -pb.nfx;
        ny = -pb.nfy;
      end
      KIND_CC: begin
        // coincident centers fall back to +x
        nx = pb.dzero ? NRM_ONE  : (pb.sx ? -cx : cx);
        ny = pb.dzero ? NRM_ZERO : (pb.sy ? -cy : cy);
      end
      default: begin
        nx = NRM_ZERO;
        ny = NRM_ZERO;
      end
    endcase
    out_hit = pb.hit && !pb.trig;
    out_pen = out_hit ? pb.pen : '0;
    out_nx  = out_hit ? nx : NRM_ZERO;
    out_ny  = out_hit ? ny : NRM_ZERO;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.hit         <= out_hit;
      rsp.penetration <= out_pen;
      rsp.normal_x    <= out_nx;
      rsp.normal_y    <= out_ny;
    end
  end

  // valid bits, cleared by reset, shift with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      sq_v <= '0;
      v6   <= 1'b0;
      dv_v <= '0;
      ov   <= 1'b0;
    end else if (en) begin
      v1   <= req.valid;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      sq_v <= {sq_v[SQ_LAT-2:0], v5};
      v6   <= sq_v[SQ_LAT-1];
      dv_v <= {dv_v[DV_LAT-2:0], v6};
      ov   <= dv_v[DV_LAT-1];
    end
  end

  assign rsp.valid = ov;

  // ---- checks ----
  `BCCM_ASSERT_SAME(a_miss_is_zero, clk, rst, rsp.valid && !rsp.hit, rsp.penetration == '0 && rsp.normal_x == NRM_ZERO && rsp.normal_y == NRM_ZERO)
  `BCCM_ASSERT_SAME(a_no_take_on_stall, clk, rst, rsp.valid && !rsp.ready, !req.ready)
  `BCCM_ASSERT_SAME(a_normal_range, clk, rst, rsp.valid, rsp.normal_x <= NRM_ONE && rsp.normal_x >= NRM_NEG && rsp.normal_y <= NRM_ONE && rsp.normal_y >= NRM_NEG)

endmodule

`default_nettype wire
